// File: src/cramer_3x3_linear_solver_core_assert.svh
// Assertion macros used by the checker file of the solver core.
`ifndef CRAMER_3X3_LINEAR_SOLVER_CORE_ASSERT_SVH
`define CRAMER_3X3_LINEAR_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define CR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cr_pkg.sv
// Package of the 3x3 solver: widths, pipeline stage map, types and index helpers.
`default_nettype none
package cr_pkg;

  // Field format
  localparam int DW = 32;
  localparam int FB = 16;

  // Internal widths
  localparam int PW   = 2 * DW;      // 2x2 minor product
  localparam int CW   = PW + 1;      // cofactor
  localparam int SW   = 3 * DW + 2;  // determinant sum
  localparam int AW   = SW - 1;      // determinant magnitude
  localparam int UW   = AW + FB;     // scaled numerator magnitude
  localparam int QW   = DW + 1;      // quotient bits kept before saturation
  localparam int CMPW = AW + QW;     // divisor shifted by the top quotient bit

  // Stage map
  localparam int ST_COF  = 0;
  localparam int ST_DET  = 2;
  localparam int ST_DIV  = 4;
  localparam int DIV_NST = QW + 1;
  localparam int ST_OUT  = ST_DIV + DIV_NST;
  localparam int NST     = ST_OUT + 1;

  // Port widths
  localparam int IN_W  = 12 * DW;
  localparam int OUT_W = 3 * DW;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    logic [QW-1:0] mag;
    logic          ovf;
    logic          neg;
  } quo_t;

  // Lower and upper of the two indices other than i
  function automatic int idx_lo(input int i);
    return (i == 0) ? 1 : 0;
  endfunction

  function automatic int idx_hi(input int i);
    return (i == 2) ? 1 : 2;
  endfunction

endpackage
`default_nettype wire

// File: src/cr_cof.sv
// Cofactor stages: 2x2 minor products, then signed cofactors of all nine entries.
`default_nettype none
module cr_cof (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  cr_pkg::elem_t m_i   [3][3],
  input  cr_pkg::elem_t d_i   [3],
  output cr_pkg::cof_t  cof_o [3][3],
  output cr_pkg::elem_t m0_o  [3],
  output cr_pkg::elem_t d_o   [3]
);
  import cr_pkg::*;

  logic signed [PW-1:0] pa_q [3][3];
  logic signed [PW-1:0] pb_q [3][3];
  elem_t m0_s0_q [3];
  elem_t d_s0_q  [3];
  cof_t  cof_q   [3][3];
  elem_t m0_q    [3];
  elem_t d_q     [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int R1 = idx_lo(r);
    localparam int R2 = idx_hi(r);

    // Column 0 and right-hand side ride along
    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        m0_s0_q[r] <= m_i[r][0];
        d_s0_q[r]  <= d_i[r];
      end
      if (en_i[1]) begin
        m0_q[r] <= m0_s0_q[r];
        d_q[r]  <= d_s0_q[r];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int C1 = idx_lo(c);
      localparam int C2 = idx_hi(c);

      // Minor products
      always_ff @(posedge clk_i) begin
        if (en_i[0]) begin
          pa_q[r][c] <= m_i[R1][C1] * m_i[R2][C2];
          pb_q[r][c] <= m_i[R1][C2] * m_i[R2][C1];
        end
      end

      // Cofactor sign folded into the subtraction order
      always_ff @(posedge clk_i) begin
        if (en_i[1]) begin
          if (((r + c) % 2) == 0) begin
            cof_q[r][c] <= CW'(pa_q[r][c]) - CW'(pb_q[r][c]);
          end else begin
            cof_q[r][c] <= CW'(pb_q[r][c]) - CW'(pa_q[r][c]);
          end
        end
      end

      assign cof_o[r][c] = cof_q[r][c];
    end

    assign m0_o[r] = m0_q[r];
    assign d_o[r]  = d_q[r];
  end

endmodule
`default_nettype wire

// File: src/cr_det.sv
// Determinant stages: split cofactor products, then column expansions for D and N0..N2.
`default_nettype none
module cr_det (
  input  logic          clk_i,
  input  logic [1:0]    en_i,
  input  cr_pkg::cof_t  cof_i [3][3],
  input  cr_pkg::elem_t m0_i  [3],
  input  cr_pkg::elem_t d_i   [3],
  output cr_pkg::sum_t  det_o,
  output cr_pkg::sum_t  num_o [3]
);
  import cr_pkg::*;

  logic signed [CW-1:0] lo_q  [4][3];
  logic signed [CW-1:0] hi_q  [4][3];
  sum_t                 sum_d [4];
  sum_t                 sum_q [4];

  // Term 0 is D (column 0 times its cofactors), term t is N(t-1)
  for (genvar t = 0; t < 4; t++) begin : g_term
    localparam int CC = (t == 0) ? 0 : t - 1;
    for (genvar r = 0; r < 3; r++) begin : g_row
      elem_t x;
      if (t == 0) begin : g_m
        assign x = m0_i[r];
      end else begin : g_d
        assign x = d_i[r];
      end

      // Low and high partial products of a 32 x 65 multiply
      always_ff @(posedge clk_i) begin
        if (en_i[0]) begin
          lo_q[t][r] <= x * $signed({1'b0, cof_i[r][CC][DW-1:0]});
          hi_q[t][r] <= x * $signed(cof_i[r][CC][CW-1:DW]);
        end
      end
    end

    // Recombine and sum the three rows
    always_comb begin
      sum_d[t] = '0;
      for (int r = 0; r < 3; r++) begin
        sum_d[t] = sum_d[t] + (SW'(hi_q[t][r]) <<< DW) + SW'(lo_q[t][r]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[1]) begin
        sum_q[t] <= sum_d[t];
      end
    end
  end

  assign det_o = sum_q[0];
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign num_o[i] = sum_q[i + 1];
  end

endmodule
`default_nettype wire

// File: src/cr_div.sv
// Divider pipeline: magnitudes, then one restoring quotient bit per stage on three lanes.
`default_nettype none
module cr_div (
  input  logic                       clk_i,
  input  logic [cr_pkg::DIV_NST-1:0] en_i,
  input  cr_pkg::sum_t               det_i,
  input  cr_pkg::sum_t               num_i [3],
  output cr_pkg::quo_t               quo_o [3],
  output logic                       zero_o
);
  import cr_pkg::*;

  logic [AW-1:0] ud_q   [DIV_NST];
  logic          zero_q [DIV_NST];
  logic [UW-1:0] rem_q  [3][DIV_NST];
  quo_t          quo_q  [3][DIV_NST];
  sum_t          det_abs;
  sum_t          num_abs [3];

  // Magnitudes
  always_comb begin
    det_abs = det_i[SW-1] ? -det_i : det_i;
    for (int l = 0; l < 3; l++) begin
      num_abs[l] = num_i[l][SW-1] ? -num_i[l] : num_i[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ud_q[0]   <= det_abs[AW-1:0];
      zero_q[0] <= (det_i == '0);
      for (int l = 0; l < 3; l++) begin
        rem_q[l][0]     <= UW'(num_abs[l][AW-1:0]) << FB;
        quo_q[l][0].mag <= '0;
        quo_q[l][0].ovf <= 1'b0;
        quo_q[l][0].neg <= num_i[l][SW-1] ^ det_i[SW-1];
      end
    end
  end

  // Quotient bit J is settled in stage s
  for (genvar s = 1; s < DIV_NST; s++) begin : g_stg
    localparam int J = QW - s;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        ud_q[s]   <= ud_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CMPW-1:0] dsh;
      logic            ge;
      logic [UW-1:0]   rem_d;
      quo_t            quo_d;

      always_comb begin
        dsh   = CMPW'(ud_q[s-1]) << J;
        ge    = CMPW'(rem_q[l][s-1]) >= dsh;
        rem_d = ge ? (rem_q[l][s-1] - dsh[UW-1:0]) : rem_q[l][s-1];
        quo_d = quo_q[l][s-1];
        quo_d.mag[J] = ge;
        // Quotient needs more than QW bits
        if (s == 1) begin
          quo_d.ovf = CMPW'(rem_q[l][s-1]) >= (CMPW'(ud_q[s-1]) << QW);
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[l][s] <= rem_d;
          quo_q[l][s] <= quo_d;
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = quo_q[l][DIV_NST-1];
  end
  assign zero_o = zero_q[DIV_NST-1];

endmodule
`default_nettype wire

// File: src/cramer_3x3_linear_solver_core.sv
// Top level of the 3x3 Cramer's rule solver: stream ports, stage flow control, saturation.
// Solves M x = d for a 3x3 matrix of signed Q16.16 values and returns x in Q16.16,
// truncated toward zero and saturated, with singular (D == 0, x = 0) and overflow flags.
// One system is accepted every clock unless the output stalls with every stage full.
// An item passes two cofactor stages, two determinant stages and a magnitude stage, then
// the 33 divider stages that resolve one quotient bit per stage, then one output
// register. Each stage holds its item and lets bubbles collapse, so a stall on the
// output side loses nothing and the input keeps filling empty stages.
`default_nettype none
module cramer_3x3_linear_solver_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // row_a_x, row_a_y, row_a_z, row_b_x, row_b_y, row_b_z,
  // row_c_x, row_c_y, row_c_z, rhs_0, rhs_1, rhs_2
  input  logic [cr_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // sol_0, sol_1, sol_2
  output logic [cr_pkg::OUT_W-1:0]  m_axis_tdata,
  // singular, overflow
  output logic [1:0]                m_axis_tuser
);
  import cr_pkg::*;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  elem_t m_in [3][3];
  elem_t d_in [3];
  cof_t  cof  [3][3];
  elem_t m0   [3];
  elem_t d_s  [3];
  sum_t  det;
  sum_t  num  [3];
  quo_t  quo  [3];
  logic  zero;

  logic [DW-1:0] sol_d [3];
  logic [DW-1:0] sol_q [3];
  logic          ovf_d;
  logic          sing_q;
  logic          ovf_q;

  // Unpack input transaction
  for (genvar r = 0; r < 3; r++) begin : g_unpack
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign m_in[r][c] = s_axis_tdata[(r*3+c)*DW +: DW];
    end
    assign d_in[r] = s_axis_tdata[(9+r)*DW +: DW];
  end

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  cr_cof u_cof (
    .clk_i (clk_i),
    .en_i  (en[ST_COF+1:ST_COF]),
    .m_i   (m_in),
    .d_i   (d_in),
    .cof_o (cof),
    .m0_o  (m0),
    .d_o   (d_s)
  );

  cr_det u_det (
    .clk_i (clk_i),
    .en_i  (en[ST_DET+1:ST_DET]),
    .cof_i (cof),
    .m0_i  (m0),
    .d_i   (d_s),
    .det_o (det),
    .num_o (num)
  );

  cr_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[ST_DIV+DIV_NST-1:ST_DIV]),
    .det_i  (det),
    .num_i  (num),
    .quo_o  (quo),
    .zero_o (zero)
  );

  // Sign and saturation
  always_comb begin
    ovf_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (quo[l].ovf || (!quo[l].neg && (quo[l].mag[QW-1:DW-1] != '0))) begin
        sol_d[l] = quo[l].neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        ovf_d    = 1'b1;
      end else if (quo[l].neg && (quo[l].mag > (QW'(1) << (DW-1)))) begin
        sol_d[l] = {1'b1, {(DW-1){1'b0}}};
        ovf_d    = 1'b1;
      end else begin
        sol_d[l] = quo[l].neg ? -quo[l].mag[DW-1:0] : quo[l].mag[DW-1:0];
      end
      if (zero) begin
        sol_d[l] = '0;
      end
    end
    if (zero) begin
      ovf_d = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      for (int l = 0; l < 3; l++) begin
        sol_q[l] <= sol_d[l];
      end
      sing_q <= zero;
      ovf_q  <= ovf_d;
    end
  end

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tdata  = {sol_q[2], sol_q[1], sol_q[0]};
  assign m_axis_tuser  = {ovf_q, sing_q};

endmodule
`default_nettype wire

// File: src/cr_chk.sv
// Port checker for the solver core and its bind to the top level.
`default_nettype none
`include "cramer_3x3_linear_solver_core_assert.svh"
module cr_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [cr_pkg::OUT_W-1:0] m_axis_tdata,
  input logic [1:0]               m_axis_tuser
);
  import cr_pkg::*;

  logic [DW-1:0] s0;
  logic [DW-1:0] s1;
  logic [DW-1:0] s2;
  logic          any_sat;

  assign s0 = m_axis_tdata[DW-1:0];
  assign s1 = m_axis_tdata[2*DW-1:DW];
  assign s2 = m_axis_tdata[3*DW-1:2*DW];
  assign any_sat =
    (s0 == {1'b0, {(DW-1){1'b1}}}) || (s0 == {1'b1, {(DW-1){1'b0}}}) ||
    (s1 == {1'b0, {(DW-1){1'b1}}}) || (s1 == {1'b1, {(DW-1){1'b0}}}) ||
    (s2 == {1'b0, {(DW-1){1'b1}}}) || (s2 == {1'b1, {(DW-1){1'b0}}});

  // Stalled result transaction holds
  `CR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Singular system gives zero solution and no overflow
  `CR_ASSERT_IMP(a_sing_zero, m_axis_tvalid && m_axis_tuser[0],
    (m_axis_tdata == '0) && !m_axis_tuser[1], "singular result not zero")

  // Overflow means some element sits at a range limit
  `CR_ASSERT_IMP(a_ovf_sat, m_axis_tvalid && m_axis_tuser[1], any_sat,
    "overflow without saturated element")

endmodule

bind cramer_3x3_linear_solver_core cr_chk u_chk (.*);
`default_nettype wire

// File: tb/tb_cramer_3x3_linear_solver_core.sv
// Testbench for the 3x3 Cramer's rule solver core: directed and random systems, scoreboarded.
`timescale 1ns / 100ps
`default_nettype none
module tb_cramer_3x3_linear_solver_core;
  import cr_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef elem_t mat_t [3][3];
  typedef struct {
    logic [OUT_W-1:0] sol;
    logic [1:0]       flags;  // singular, overflow
  } solution_t;

  localparam wide_t SOL_MAX = wide_t'(32'sh7fffffff);
  localparam wide_t SOL_MIN = -wide_t'(64'sh80000000);

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  logic [IN_W-1:0] pending_systems [$];
  solution_t       expected_solutions [$];
  int              errors = 0;
  int              n_solved = 0;
  int              n_singular = 0;
  int              n_saturated = 0;
  int              tx_idle_pct = 0;
  int              rx_stall_pct = 0;
  int              rx_hold_cycles = 0;
  bit              sys_taken = 1'b0;

  cramer_3x3_linear_solver_core uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Exact 3x3 determinant by expansion along row 0
  function automatic wide_t det3(input mat_t m);
    wide_t e [3][3];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        e[r][c] = m[r][c];
    return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
         - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
         + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
  endfunction

  // Solution of one packed system
  function automatic solution_t solve_system(input logic [IN_W-1:0] sys);
    mat_t      m, w;
    elem_t     rhs [3];
    wide_t     det, num, q;
    solution_t s;
    for (int k = 0; k < 9; k++)
      m[k / 3][k % 3] = sys[k*DW +: DW];
    for (int k = 0; k < 3; k++)
      rhs[k] = sys[(9 + k)*DW +: DW];
    s.sol = '0;
    s.flags = 2'b00;
    det = det3(m);
    if (det == 0) begin
      s.flags[0] = 1'b1;
      return s;
    end
    for (int i = 0; i < 3; i++) begin
      w = m;
      for (int r = 0; r < 3; r++)
        w[r][i] = rhs[r];
      num = det3(w) <<< FB;
      q = num / det;  // truncates toward zero
      if (q > SOL_MAX) begin
        q = SOL_MAX;
        s.flags[1] = 1'b1;
      end else if (q < SOL_MIN) begin
        q = SOL_MIN;
        s.flags[1] = 1'b1;
      end
      s.sol[i*DW +: DW] = q[DW-1:0];
    end
    return s;
  endfunction

  function automatic logic [IN_W-1:0] pack_system(input mat_t m, input elem_t d0,
                                                  input elem_t d1, input elem_t d2);
    logic [IN_W-1:0] v;
    for (int k = 0; k < 9; k++)
      v[k*DW +: DW] = m[k / 3][k % 3];
    v[9*DW +: DW]  = d0;
    v[10*DW +: DW] = d1;
    v[11*DW +: DW] = d2;
    return v;
  endfunction

  function automatic elem_t rand_elem(input int kind);
    case (kind)
      0: return elem_t'($urandom());
      1: return elem_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;  // about +-8.0
      2: return elem_t'($urandom_range(0, 64)) - 32'sh20;                    // few LSBs
      default: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // Random system: mostly well-conditioned values, some singular, some extreme
  function automatic logic [IN_W-1:0] rand_system();
    mat_t  m;
    elem_t d [3];
    int    kind, shape;
    kind = $urandom_range(9);
    kind = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
    for (int k = 0; k < 9; k++)
      m[k / 3][k % 3] = rand_elem(($urandom_range(7) == 0) ? $urandom_range(3) : kind);
    for (int k = 0; k < 3; k++)
      d[k] = rand_elem(($urandom_range(3) == 0) ? 0 : kind);
    shape = $urandom_range(9);
    if (shape == 0) begin
      m[2] = m[0];                        // repeated row
    end else if (shape == 1) begin
      for (int r = 0; r < 3; r++)
        m[r][$urandom_range(2)] = '0;     // may zero a column
    end else if (shape == 2) begin
      for (int c = 0; c < 3; c++)
        m[1][c] = -m[0][c];               // dependent row
    end
    return pack_system(m, d[0], d[1], d[2]);
  endfunction

  // Input driver: new values at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || sys_taken) begin
        if (pending_systems.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tdata <= pending_systems.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure, with an optional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles <= rx_hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Input transaction: predict the solution
  always @(posedge clk_i) begin
    sys_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_solutions.push_back(solve_system(s_axis_tdata));
  end

  // Output transaction: compare with the oldest prediction
  always @(posedge clk_i) begin
    solution_t exp_s;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_solutions.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result %h flags %b", $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_s = expected_solutions.pop_front();
        n_solved++;
        n_singular += exp_s.flags[0];
        n_saturated += exp_s.flags[1];
        for (int i = 0; i < 3; i++)
          if (m_axis_tdata[i*DW +: DW] !== exp_s.sol[i*DW +: DW]) begin
            errors++;
            if (errors <= 10)
              $display("%0t: sol_%0d expected %h got %h", $realtime, i,
                       exp_s.sol[i*DW +: DW], m_axis_tdata[i*DW +: DW]);
          end
        if (m_axis_tuser[0] !== exp_s.flags[0]) begin
          errors++;
          if (errors <= 10)
            $display("%0t: singular expected %b got %b", $realtime,
                     exp_s.flags[0], m_axis_tuser[0]);
        end
        if (m_axis_tuser[1] !== exp_s.flags[1]) begin
          errors++;
          if (errors <= 10)
            $display("%0t: overflow expected %b got %b", $realtime,
                     exp_s.flags[1], m_axis_tuser[1]);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Wait at clock edges until nothing is queued, offered or owed
  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (pending_systems.size() != 0 || s_axis_tvalid ||
               expected_solutions.size() != 0);
  endtask

  initial begin
    mat_t ident, m;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        ident[r][c] = (r == c) ? 32'sh0001_0000 : '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed systems
    pending_systems.push_back(pack_system(ident, 32'sh0003_0000, -32'sh0002_8000, 32'sh7fffffff));
    pending_systems.push_back(pack_system(ident, 32'sh80000000, 32'sh1, -32'sh1));
    m = '{default: '0};
    pending_systems.push_back(pack_system(m, 32'sh1, 32'sh1, 32'sh1));          // all zero
    m = '{default: 32'sh7fffffff};
    pending_systems.push_back(pack_system(m, 32'sh7fffffff, 32'sh0, 32'sh80000000));
    m = '{default: 32'sh80000000};
    pending_systems.push_back(pack_system(m, 32'sh80000000, 32'sh80000000, 32'sh80000000));
    m = '{'{32'sh1, 0, 0}, '{0, 32'sh1, 0}, '{0, 0, 32'sh1}};                 // tiny diagonal
    pending_systems.push_back(pack_system(m, 32'sh7fffffff, 32'sh80000000, 32'sh1));
    pending_systems.push_back(pack_system(m, 32'sh0, 32'sh0, 32'sh0));
    m = '{'{32'sh80000000, 32'sh7fffffff, 32'sh1}, '{32'sh7fffffff, 32'sh80000000, -32'sh1},
          '{32'sh1, -32'sh1, 32'sh80000000}};
    pending_systems.push_back(pack_system(m, 32'sh7fffffff, 32'sh80000000, -32'sh1));
    m = '{'{32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000},
          '{-32'sh0003_0000, -32'sh0001_0000, 32'sh0002_0000},
          '{-32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000}};
    pending_systems.push_back(pack_system(m, 32'sh0008_0000, -32'sh000b_0000, -32'sh0003_0000));
    pending_systems.push_back(pack_system(m, -32'sh1, 32'sh1, 32'sh7fffffff));
    m[2] = m[0];                                                               // repeated row
    pending_systems.push_back(pack_system(m, 32'sh0001_0000, 32'sh0, 32'sh0));
    m = '{'{32'sh0003_0000, 0, 0}, '{0, 32'sh0003_0000, 0}, '{0, 0, -32'sh0003_0000}};
    pending_systems.push_back(pack_system(m, 32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000));
    for (int k = 0; k < 8; k++)
      pending_systems.push_back(rand_system());
    drain();

    // Random phases: long hold-off, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 13 : 0;
      rx_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 13 : 0;
      if (ph == 0)
        rx_hold_cycles = 300;  // long back-pressure while the sender keeps going
      for (int k = 0; k < 270; k++)
        pending_systems.push_back(rand_system());
      drain();
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (60) @(posedge clk_i);

    $display("Solved %0d systems: %0d singular, %0d saturated, over four flow-control mixes",
             n_solved, n_singular, n_saturated);
    if (errors == 0 && expected_solutions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches %0d, results still owed %0d", errors, expected_solutions.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
